// ===== rtl/eta_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eta_pkg
// Types and codes shared by the epoch timestamp aggregator: request kinds,
// register indexes, the bucket table entry and the emitted record.
// ----------------------------------------------------------------------------
package eta_pkg;

  localparam int SEQ_W    = 16;
  localparam int TIME_W   = 32;
  localparam int TS_W     = 40;
  localparam int ID_W     = 8;
  localparam int TMO_W    = 16;
  localparam int SLOTS    = 4;
  localparam int SLOT_W   = 2;
  localparam int REQ_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W    = 16;

  // request kinds carried in the input tuser
  localparam logic [REQ_W-1:0] REQ_ARRIVAL = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FLUSH   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd4;

  // one bucket as held in the table memory
  typedef struct packed {
    logic [SEQ_W-1:0]             seq;
    logic [TIME_W-1:0]            last_seen;
    logic [SLOTS-1:0][TS_W-1:0]   ts;
  } ent_t;

  // one emitted record, without the last flag
  typedef struct packed {
    logic [SEQ_W-1:0]             seq;
    logic [SLOTS-1:0]             mask;
    logic [SLOTS-1:0][TS_W-1:0]   ts;
    logic                         timed;
  } rec_t;

endpackage

`default_nettype wire

// ===== rtl/epoch_timestamp_aggregator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_timestamp_aggregator
// Groups beacon receive timestamps by epoch sequence number in a bucket
// table kept in one synchronous memory; emits complete, evicted, timed-out
// and flushed buckets as records.
// ----------------------------------------------------------------------------
// Flow: an arrival scans the table with a read per bucket, then reads the target
//   bucket and writes it back, with a completion step when it completes its
//   bucket; unknown beacons and unused words are dropped in the idle state.
// A tick or flush scans the table only; output stalls can hold both. One
//   item is worked on at a time: input is taken only in the idle state.
// Reset (rst, synchronous): all buckets free, registers to defaults; no table clear.
// ----------------------------------------------------------------------------
module epoch_timestamp_aggregator #(
  parameter int NUM_BUCKETS = 8,
  parameter int NUM_ANCHORS = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [eta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [eta_pkg::CFG_W-1:0]      cfg_data,
  // input words
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // beacon_id[7:0], epoch_seq[23:8], rx_timestamp[63:24], now_ms[95:64]
  input  wire logic [95:0]                    s_tdata,
  // req_type[1:0]
  input  wire logic [1:0]                     s_tuser,
  // output words
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // out_seq[15:0], anchor_mask[19:16], slot0_ts[59:20], slot1_ts[99:60],
  // slot2_ts[139:100], slot3_ts[179:140], zero fill[183:180]
  output logic [183:0]                        m_tdata,
  // timeout_flag[0]
  output logic                                m_tuser,
  output logic                                m_tlast
);
  import eta_pkg::*;

  localparam int BW = $clog2(NUM_BUCKETS);
  localparam logic [BW-1:0]    LAST_IDX = BW'(NUM_BUCKETS - 1);
  localparam logic [BW:0]      DEPTH    = (BW+1)'(NUM_BUCKETS);
  localparam logic [SLOTS-1:0] FULL     = SLOTS'((1 << NUM_ANCHORS) - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_MERGE, S_CMPL, S_FIN
  } state_t;

  state_t state;

  // configuration registers
  logic [ID_W-1:0]  beacon_ids [SLOTS];
  logic [TMO_W-1:0] timeout;

  // per-bucket flags in flip-flops
  logic [NUM_BUCKETS-1:0] used;
  logic [SLOTS-1:0]       mask [NUM_BUCKETS];

  // bucket table memory
  ent_t             mem [NUM_BUCKETS];
  ent_t             rd_data;
  logic             mem_re;
  logic [BW-1:0]    mem_ra;
  logic             mem_we;
  ent_t             mem_wd;

  // latched item
  logic [REQ_W-1:0]  req;
  logic [SLOT_W-1:0] hit_slot;
  logic [SEQ_W-1:0]  seq_r;
  logic [TS_W-1:0]   ts_r;
  logic [TIME_W-1:0] now_r;

  // scan state
  logic [BW:0]       rd_idx;
  logic [BW-1:0]     ev_idx;
  logic              ev_valid;
  logic              found;
  logic [BW-1:0]     match;
  logic [BW-1:0]     oldest;
  logic [TIME_W-1:0] best;
  logic [BW-1:0]     tgt;
  logic              fresh;
  logic              evict;
  rec_t              cmp_rec;

  // hold and output registers
  rec_t hrec;
  logic hvalid;
  rec_t orec;
  logic ovalid;
  logic olast;

  // combinational control
  logic              in_hit;
  logic [SLOT_W-1:0] in_slot;
  logic              can_push;
  logic              scan_adv;
  logic [TIME_W-1:0] ev_age;
  logic              ev_emit;
  logic              any_free;
  logic [BW-1:0]     first_free;
  logic [BW-1:0]     tgt_sel;
  logic [SLOTS-1:0]  new_mask;
  ent_t              merged;
  logic              merge_go;
  logic              push_en;
  rec_t              push_rec;
  logic              fin_en;

  function automatic rec_t make_rec(ent_t e, logic [SLOTS-1:0] m, logic t);
    rec_t r;
    r.seq   = e.seq;
    r.mask  = m;
    for (int s = 0; s < SLOTS; s++) begin
      r.ts[s] = m[s] ? e.ts[s] : '0;
    end
    r.timed = t;
    return r;
  endfunction

  // anchor slot lookup, lowest slot wins
  always_comb begin
    in_hit  = 1'b0;
    in_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (i < NUM_ANCHORS && beacon_ids[i] == s_tdata[7:0]) begin
        in_hit  = 1'b1;
        in_slot = SLOT_W'(i);
      end
    end
  end

  // first free bucket
  always_comb begin
    first_free = '0;
    for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        first_free = BW'(i);
      end
    end
    any_free = ~&used;
  end

  // sequencer control
  always_comb begin
    can_push = !hvalid || !ovalid || m_tready;
    scan_adv = (state == S_SCAN) && (req == REQ_ARRIVAL || can_push);
    ev_age   = now_r - rd_data.last_seen;
    ev_emit  = used[ev_idx] && (mask[ev_idx] != '0) &&
               (req == REQ_FLUSH ||
                (req == REQ_TICK && ev_age >= {{(TIME_W-TMO_W){1'b0}}, timeout}));

    if (found) begin
      tgt_sel = match;
    end else if (any_free) begin
      tgt_sel = first_free;
    end else begin
      tgt_sel = oldest;
    end

    // read port
    mem_re = 1'b0;
    mem_ra = '0;
    if (scan_adv && rd_idx < DEPTH) begin
      mem_re = 1'b1;
      mem_ra = rd_idx[BW-1:0];
    end else if (state == S_DECIDE) begin
      mem_re = 1'b1;
      mem_ra = tgt_sel;
    end

    // merge of the arrival into the target bucket
    new_mask         = (fresh ? '0 : mask[tgt]) | (SLOTS'(1) << hit_slot);
    merged.seq       = seq_r;
    merged.last_seen = now_r;
    for (int s = 0; s < SLOTS; s++) begin
      merged.ts[s] = (SLOT_W'(s) == hit_slot) ? ts_r : rd_data.ts[s];
    end
    merge_go = (state == S_MERGE) && (!evict || can_push);
    mem_we   = merge_go;
    mem_wd   = merged;

    // record pushes into the hold register
    push_en  = 1'b0;
    push_rec = cmp_rec;
    if (scan_adv && ev_valid && ev_emit) begin
      push_en  = 1'b1;
      push_rec = make_rec(rd_data, mask[ev_idx], 1'b1);
    end else if (merge_go && evict) begin
      push_en  = 1'b1;
      push_rec = make_rec(rd_data, mask[tgt], 1'b1);
    end else if (state == S_CMPL && can_push) begin
      push_en  = 1'b1;
    end
    fin_en = (state == S_FIN) && can_push;
  end

  // table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tgt] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        beacon_ids[i] <= ID_W'(i + 1);
      end
      timeout <= TMO_W'(100);
    end else if (cfg_we) begin
      case (cfg_index) inside
        [CFG_ANCHOR_A:CFG_ANCHOR_D]: begin
          beacon_ids[cfg_index[SLOT_W-1:0]] <= cfg_data[ID_W-1:0];
        end
        CFG_TIMEOUT: begin
          timeout <= cfg_data[TMO_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer, bucket flags and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      used   <= '0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        mask[i] <= '0;
      end
      hvalid <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      // output and hold registers
      if (hvalid && (push_en || fin_en)) begin
        orec   <= hrec;
        olast  <= !push_en;
        ovalid <= 1'b1;
      end else if (ovalid && m_tready) begin
        ovalid <= 1'b0;
      end
      if (push_en) begin
        hrec   <= push_rec;
        hvalid <= 1'b1;
      end else if (fin_en) begin
        hvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req      <= s_tuser;
            hit_slot <= in_slot;
            seq_r    <= s_tdata[23:8];
            ts_r     <= s_tdata[63:24];
            now_r    <= s_tdata[95:64];
            rd_idx   <= '0;
            ev_valid <= 1'b0;
            found    <= 1'b0;
            if ((s_tuser == REQ_ARRIVAL && in_hit) || s_tuser == REQ_TICK ||
                s_tuser == REQ_FLUSH) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_adv) begin
            // issue the next read
            if (rd_idx < DEPTH) begin
              ev_idx   <= rd_idx[BW-1:0];
              ev_valid <= 1'b1;
              rd_idx   <= rd_idx + 1'b1;
            end else begin
              ev_valid <= 1'b0;
            end
            // evaluate the word from the previous read
            if (ev_valid) begin
              if (req == REQ_ARRIVAL) begin
                if (!found && used[ev_idx] && rd_data.seq == seq_r) begin
                  found <= 1'b1;
                  match <= ev_idx;
                end
                if (used[ev_idx] && (ev_idx == '0 || ev_age > best)) begin
                  best   <= ev_age;
                  oldest <= ev_idx;
                end
              end else if (ev_emit) begin
                used[ev_idx] <= 1'b0;
                mask[ev_idx] <= '0;
              end
              if (ev_idx == LAST_IDX) begin
                state <= (req == REQ_ARRIVAL) ? S_DECIDE : S_FIN;
              end
            end
          end
        end
        S_DECIDE: begin
          tgt   <= tgt_sel;
          fresh <= !found;
          evict <= !found && !any_free;
          state <= S_MERGE;
        end
        S_MERGE: begin
          if (merge_go) begin
            used[tgt] <= 1'b1;
            mask[tgt] <= new_mask;
            cmp_rec   <= make_rec(merged, new_mask, 1'b0);
            state     <= ((new_mask & FULL) == FULL) ? S_CMPL : S_FIN;
          end
        end
        S_CMPL: begin
          if (can_push) begin
            used[tgt] <= 1'b0;
            mask[tgt] <= '0;
            state     <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_en) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ports
  assign s_tready = (state == S_IDLE) && !rst;
  assign m_tvalid = ovalid;
  assign m_tdata  = {4'b0, orec.ts, orec.mask, orec.seq};
  assign m_tuser  = orec.timed;
  assign m_tlast  = olast;

endmodule

`default_nettype wire

// ===== test/epoch_timestamp_aggregator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_timestamp_aggregator_tb
// Self-checking bench for the epoch timestamp aggregator. It drives arrival,
// tick and flush words and keeps a shadow of the bucket table and registers.
// Every emitted record is compared field by field with the oldest predicted
// one. Directed cases come first, then three random phases with different
// idling on both sides.
// ----------------------------------------------------------------------------
module epoch_timestamp_aggregator_tb;
  import eta_pkg::*;

  localparam int NB             = 8;
  localparam int NA             = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = NB + 16;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // predicted record plus its last flag
  typedef struct packed {
    rec_t rec;
    logic last;
  } out_word_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  // beacon_id[7:0], epoch_seq[23:8], rx_timestamp[63:24], now_ms[95:64]
  logic [95:0]          s_tdata   = '0;
  // req_type[1:0]
  logic [1:0]           s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  // out_seq[15:0], anchor_mask[19:16], slot0_ts..slot3_ts[179:20], zero fill
  logic [183:0]         m_tdata;
  // timeout_flag[0]
  logic                 m_tuser;
  logic                 m_tlast;

  // shadow of the bucket table and registers
  logic                       bkt_used [NB];
  logic [SEQ_W-1:0]           bkt_seq  [NB];
  logic [TIME_W-1:0]          bkt_seen [NB];
  logic [SLOTS-1:0]           bkt_mask [NB];
  logic [SLOTS-1:0][TS_W-1:0] bkt_ts   [NB];
  logic [ID_W-1:0]            anchor_reg [SLOTS];
  logic [TMO_W-1:0]           timeout_reg;

  out_word_t         pending_records [$];
  int                fail_count    = 0;
  int                src_idle_pct  = 0;
  int                sink_idle_pct = 0;
  int                quiet_cycles  = 0;
  logic [TIME_W-1:0] now_cur       = '0;
  logic [SEQ_W-1:0]  seq_base      = '0;

  epoch_timestamp_aggregator #(
    .NUM_BUCKETS(NB),
    .NUM_ANCHORS(NA)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // clock
  always #6 clk = ~clk;

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d records still awaited", $time,
               pending_records.size());
      $display("epoch_timestamp_aggregator regression: fail");
      $finish;
    end
  end

  function automatic logic [TS_W-1:0] rand_ts();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TS_W-1:0];
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // record checker
  always @(posedge clk) begin
    out_word_t want;
    int s;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_records.size() == 0) begin
        $display("%0t: unexpected record: expected none, actual data %h user %b last %b",
                 $time, m_tdata, m_tuser, m_tlast);
        fail_count++;
      end else begin
        want = pending_records.pop_front();
        check_field("out_seq", 64'(want.rec.seq), 64'(m_tdata[15:0]));
        check_field("anchor_mask", 64'(want.rec.mask), 64'(m_tdata[19:16]));
        for (s = 0; s < SLOTS; s++) begin
          check_field($sformatf("slot%0d_ts", s), 64'(want.rec.ts[s]),
                      64'(m_tdata[20 + 40*s +: 40]));
        end
        check_field("timeout_flag", 64'(want.rec.timed), 64'(m_tuser));
        check_field("last", 64'(want.last), 64'(m_tlast));
      end
    end
  end

  task automatic reset_shadow();
    int i;
    for (i = 0; i < NB; i++) begin
      bkt_used[i] = 1'b0;
      bkt_seq[i]  = '0;
      bkt_seen[i] = '0;
      bkt_mask[i] = '0;
      bkt_ts[i]   = '0;
    end
    anchor_reg[0] = 8'd1;
    anchor_reg[1] = 8'd2;
    anchor_reg[2] = 8'd3;
    anchor_reg[3] = 8'd4;
    timeout_reg   = 16'd100;
  endtask

  // queue a record for bucket b if it holds anything, then free it
  task automatic emit_bucket(input int b, input logic timed, inout int n);
    out_word_t w;
    int s;
    if (bkt_mask[b] != '0) begin
      w.rec.seq  = bkt_seq[b];
      w.rec.mask = bkt_mask[b];
      for (s = 0; s < SLOTS; s++) begin
        w.rec.ts[s] = bkt_mask[b][s] ? bkt_ts[b][s] : '0;
      end
      w.rec.timed = timed;
      w.last      = 1'b0;
      pending_records.push_back(w);
      n++;
    end
    bkt_used[b] = 1'b0;
    bkt_mask[b] = '0;
    bkt_ts[b]   = '0;
  endtask

  // records caused by one accepted input word
  task automatic predict_epoch_records(input logic [REQ_W-1:0] req,
                                       input logic [ID_W-1:0] id,
                                       input logic [SEQ_W-1:0] seq,
                                       input logic [TS_W-1:0] ts,
                                       input logic [TIME_W-1:0] now);
    int n, i, slot, b;
    logic [TIME_W-1:0] age, best;
    out_word_t w;
    n = 0;
    case (req)
      REQ_ARRIVAL: begin
        // lowest matching slot wins
        slot = -1;
        for (i = NA - 1; i >= 0; i--) begin
          if (anchor_reg[i] == id) slot = i;
        end
        if (slot >= 0) begin
          b = -1;
          for (i = NB - 1; i >= 0; i--) begin
            if (bkt_used[i] && bkt_seq[i] == seq) b = i;
          end
          if (b < 0) begin
            for (i = NB - 1; i >= 0; i--) begin
              if (!bkt_used[i]) b = i;
            end
            // table full: evict the oldest, lowest index on a tie
            if (b < 0) begin
              b    = 0;
              best = '0;
              for (i = 0; i < NB; i++) begin
                age = now - bkt_seen[i];
                if (i == 0 || age > best) begin
                  best = age;
                  b    = i;
                end
              end
              emit_bucket(b, 1'b1, n);
            end
            bkt_used[b] = 1'b1;
            bkt_seq[b]  = seq;
            bkt_mask[b] = '0;
            bkt_ts[b]   = '0;
          end
          bkt_mask[b][slot] = 1'b1;
          bkt_ts[b][slot]   = ts;
          bkt_seen[b]       = now;
          if (&bkt_mask[b]) emit_bucket(b, 1'b0, n);
        end
      end
      REQ_TICK: begin
        for (i = 0; i < NB; i++) begin
          if (bkt_used[i] && (now - bkt_seen[i]) >= TIME_W'(timeout_reg)) begin
            emit_bucket(i, 1'b1, n);
          end
        end
      end
      REQ_FLUSH: begin
        for (i = 0; i < NB; i++) begin
          if (bkt_used[i]) emit_bucket(i, 1'b1, n);
        end
      end
      default: ;
    endcase
    if (n > 0) begin
      w = pending_records.pop_back();
      w.last = 1'b1;
      pending_records.push_back(w);
    end
  endtask

  // one input word, with random idle cycles ahead of it
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] id,
                           input logic [SEQ_W-1:0] seq, input logic [TS_W-1:0] ts,
                           input logic [TIME_W-1:0] now);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {now, ts, seq, id};
    do @(posedge clk); while (!s_tready);
    predict_epoch_records(req, id, seq, ts, now);
  endtask

  // hold off until every predicted record is out and the block has settled
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx <= CFG_ANCHOR_D) begin
      anchor_reg[idx - CFG_ANCHOR_A] = value[ID_W-1:0];
    end else if (idx == CFG_TIMEOUT) begin
      timeout_reg = value;
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_beacon_ids(input logic [SLOTS-1:0][ID_W-1:0] ids);
    int k;
    for (k = 0; k < SLOTS; k++) begin
      write_reg(CFG_ANCHOR_A + CFG_IDX_W'(k), CFG_W'(ids[k]));
    end
  endtask

  // distinct random anchor IDs, given timeout, fresh time and sequence base
  task automatic configure_random(input logic [TMO_W-1:0] tmo);
    logic [SLOTS-1:0][ID_W-1:0] ids;
    int k, j;
    bit clash;
    for (k = 0; k < SLOTS; k++) begin
      do begin
        ids[k] = ID_W'($urandom);
        clash  = 1'b0;
        for (j = 0; j < k; j++) begin
          if (ids[j] == ids[k]) clash = 1'b1;
        end
      end while (clash);
    end
    write_beacon_ids(ids);
    write_reg(CFG_TIMEOUT, tmo);
    now_cur  = $urandom;
    seq_base = SEQ_W'($urandom);
  endtask

  // mostly arrivals from a small window of live epochs, some noise
  task automatic random_traffic(input int count, input bit pause_midway);
    int k, r;
    logic [REQ_W-1:0] req;
    logic [ID_W-1:0]  id;
    logic [SEQ_W-1:0] seq;
    for (k = 0; k < count; k++) begin
      if (pause_midway && k == count / 2) wait_idle();
      r       = $urandom_range(0, 99);
      now_cur = now_cur + $urandom_range(0, 40);
      id      = ID_W'($urandom);
      seq     = SEQ_W'($urandom);
      req     = REQ_ARRIVAL;
      if (r < 78) begin
        id  = anchor_reg[$urandom_range(0, NA - 1)];
        seq = seq_base + SEQ_W'($urandom_range(0, 4));
        if ($urandom_range(0, 9) == 0) seq_base = seq_base + SEQ_W'($urandom_range(1, 3));
      end else if (r < 86) begin
        req = REQ_TICK;
      end else if (r < 89) begin
        req = REQ_FLUSH;
      end else if (r < 94) begin
        // stray beacon with a random id
        req = REQ_ARRIVAL;
      end else if (r < 97) begin
        req = REQ_UNUSED;
      end else begin
        req     = REQ_W'($urandom);
        now_cur = $urandom;
      end
      send_word(req, id, seq, rand_ts(), now_cur);
    end
  endtask

  // all four default anchors on one epoch, timestamp extremes
  task automatic test_complete_epoch();
    send_word(REQ_ARRIVAL, 8'd1, 16'd0, 40'd0, 32'd0);
    send_word(REQ_ARRIVAL, 8'd2, 16'd0, {TS_W{1'b1}}, 32'd0);
    send_word(REQ_ARRIVAL, 8'd3, 16'd0, 40'h55_5555_5555, 32'd1);
    send_word(REQ_ARRIVAL, 8'd4, 16'd0, 40'hAA_AAAA_AAAA, 32'd2);
    wait_idle();
  endtask

  // unknown anchors and the unused request kind leave no trace
  task automatic test_ignored_words();
    send_word(REQ_ARRIVAL, 8'd0, 16'hFFFF, {TS_W{1'b1}}, 32'hFFFF_FFFF);
    send_word(REQ_ARRIVAL, 8'hFF, 16'hFFFF, rand_ts(), 32'hFFFF_FFFF);
    send_word(REQ_UNUSED, 8'd1, 16'd7, rand_ts(), 32'd9);
    wait_idle();
  endtask

  // repeated anchor overwrites its timestamp, seen on the flush
  task automatic test_duplicate_anchor();
    send_word(REQ_ARRIVAL, 8'd1, 16'hFFFF, 40'h00_0001_2345, 32'hFFFF_FFFF);
    send_word(REQ_ARRIVAL, 8'd1, 16'hFFFF, 40'hFF_0000_0001, 32'd5);
    send_word(REQ_FLUSH, 8'd0, 16'd0, 40'd0, 32'd6);
    wait_idle();
  endtask

  // full table, ages wrap past zero, tie on the oldest goes to the lower index
  task automatic test_eviction();
    int i;
    for (i = 0; i < NB; i++) begin
      send_word(REQ_ARRIVAL, 8'd2, 16'd100 + 16'(i), rand_ts(),
                (i == 3 || i == 5) ? 32'hFFFF_FFF0 : 32'hFFFF_FFFA);
    end
    send_word(REQ_ARRIVAL, 8'd3, 16'd200, rand_ts(), 32'h0000_0010);
    wait_idle();
  endtask

  // ticks at exactly the timeout age, then flush of the rest
  task automatic test_tick_and_flush();
    send_word(REQ_TICK, ID_W'($urandom), SEQ_W'($urandom), rand_ts(), 32'h0000_0054);
    send_word(REQ_TICK, ID_W'($urandom), SEQ_W'($urandom), rand_ts(), 32'h0000_005E);
    send_word(REQ_FLUSH, ID_W'($urandom), SEQ_W'($urandom), rand_ts(), 32'h0000_0060);
    wait_idle();
  endtask

  // extreme ids, one id in two slots, zero and maximum timeout
  task automatic test_config_extremes();
    write_beacon_ids({8'h7F, 8'h00, 8'hFF, 8'h00});
    write_reg(CFG_TIMEOUT, 16'd0);
    send_word(REQ_ARRIVAL, 8'h00, 16'h1234, rand_ts(), 32'h8000_0000);
    send_word(REQ_ARRIVAL, 8'hFF, 16'h1234, rand_ts(), 32'h8000_0000);
    send_word(REQ_TICK, 8'd0, 16'd0, 40'd0, 32'h8000_0000);
    wait_idle();
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    send_word(REQ_ARRIVAL, 8'h7F, 16'h0000, rand_ts(), 32'd1000);
    send_word(REQ_TICK, 8'd0, 16'd0, 40'd0, 32'd1000 + 32'd65535);
    wait_idle();
  endtask

  // random phase, sender light and receiver heavy idling, one full drain
  task automatic test_random_slow_sink();
    src_idle_pct  = 6;
    sink_idle_pct = 74;
    configure_random(TMO_W'($urandom_range(50, 400)));
    random_traffic(160, 1'b1);
    wait_idle();
  endtask

  // random phase, sender heavy and receiver light idling, short timeouts
  task automatic test_random_slow_source();
    src_idle_pct  = 74;
    sink_idle_pct = 6;
    configure_random(TMO_W'($urandom_range(0, 60)));
    random_traffic(160, 1'b0);
    wait_idle();
  endtask

  // random phase at full rate, any timeout
  task automatic test_random_full_rate();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    configure_random(TMO_W'($urandom));
    random_traffic(160, 1'b0);
    wait_idle();
  endtask

  initial begin
    reset_shadow();
    src_idle_pct  = 6;
    sink_idle_pct = 74;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_complete_epoch();
    test_ignored_words();
    test_duplicate_anchor();
    test_eviction();
    test_tick_and_flush();
    test_config_extremes();
    test_random_slow_sink();
    test_random_slow_source();
    test_random_full_rate();
    if (fail_count == 0) begin
      $display("epoch_timestamp_aggregator regression: pass");
    end else begin
      $display("epoch_timestamp_aggregator regression: fail");
    end
    $finish;
  end

endmodule

// ===== epoch_timestamp_aggregator.f =====
rtl/eta_pkg.sv
rtl/epoch_timestamp_aggregator.sv
test/epoch_timestamp_aggregator_tb.sv
